[design/rpaa_pkg.sv]
// Shared types and constants for the rolling peak axis autoscale block.
// No dependencies; every other design file imports this package.
package rpaa_pkg;

   localparam int SPEED_W = 16;   // raw sample in tenths
   localparam int VAL_W   = 13;   // whole units, limits, threshold
   localparam int HEAD_W  = 8;    // headroom register
   localparam int CSR_IDX_W = 2;

   // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
   localparam logic [SPEED_W-1:0] DIV10_RECIP = 16'hCCCD;
   localparam int DIV10_SHIFT = 19;
   localparam int PROD_W = 2 * SPEED_W;

   localparam logic [VAL_W-1:0]  RST_THRESHOLD  = 13'd50;
   localparam logic [HEAD_W-1:0] RST_HEADROOM   = 8'd10;
   localparam logic [VAL_W-1:0]  RST_BASELINE   = 13'd60;
   localparam logic [VAL_W-1:0]  RST_LAST_LIMIT = 13'd60;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADROOM  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_WRITE  = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

[design/rpaa_req_if.sv]
// Sample channel: valid/ready plus the raw speed sample in tenths.
// Depends on rpaa_pkg.
interface rpaa_req_if;
   import rpaa_pkg::*;
   logic               valid;
   logic               ready;
   logic [SPEED_W-1:0] speed_tenths;
   modport source (output valid, output speed_tenths, input ready);
   modport sink   (input valid, input speed_tenths, output ready);
endinterface

[design/rpaa_rsp_if.sv]
// Result channel: valid/ready plus converted sample, peak, limit and change flag.
// Depends on rpaa_pkg.
interface rpaa_rsp_if;
   import rpaa_pkg::*;
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] speed_whole;
   logic [VAL_W-1:0] window_peak;
   logic [VAL_W-1:0] axis_limit;
   logic             limit_changed;
   modport source (output valid, output speed_whole, output window_peak,
                   output axis_limit, output limit_changed, input ready);
   modport sink   (input valid, input speed_whole, input window_peak,
                   input axis_limit, input limit_changed, output ready);
endinterface

[design/rpaa_div10.sv]
// Registered divide-by-ten of a 16-bit sample by reciprocal multiplication.
// Depends on rpaa_pkg.
module rpaa_div10 (
   input  logic                           clock,
   input  logic                           load,
   input  logic [rpaa_pkg::SPEED_W-1:0]   dividend,
   output logic [rpaa_pkg::VAL_W-1:0]     quotient
);
   import rpaa_pkg::*;

   logic [PROD_W-1:0] prod;
   logic [VAL_W-1:0]  quotient_ff;
   logic [VAL_W-1:0]  quotient_in;

   assign prod        = PROD_W'(dividend) * PROD_W'(DIV10_RECIP);
   assign quotient_in = prod[DIV10_SHIFT +: VAL_W];

   always_ff @(posedge clock) begin
      if (load) begin
         quotient_ff <= quotient_in;
      end
   end

   assign quotient = quotient_ff;

endmodule

[design/rpaa_window_ram.sv]
// Single-port-write, single-read window store with registered read data.
// Depends on rpaa_pkg.
module rpaa_window_ram #(
   parameter int DEPTH = 200,
   parameter int AW    = 8
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [rpaa_pkg::VAL_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [rpaa_pkg::VAL_W-1:0]  rd_data
);
   import rpaa_pkg::*;

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/rolling_peak_axis_autoscale.sv]
// Top level of the rolling peak axis autoscale block: sequencer, scan, limit logic.
// Depends on rpaa_pkg, rpaa_req_if, rpaa_rsp_if, rpaa_div10, rpaa_window_ram.
//
//   channel   dir   handshake        payload
//   req_ch    in    valid/ready      speed_tenths[15:0]
//   rsp_ch    out   valid/ready      speed_whole, window_peak, axis_limit, limit_changed
//   csr_*     in    csr_we only      csr_index[1:0], csr_wdata[12:0]
//
// A sample transaction divides the sample as it is taken, writes it to the store,
// reads each filled entry in turn through the single memory read port, lets the
// last read land and then forms the result; fill is the number of window entries
// written since reset (at most WINDOW).
// Reset is synchronous; entries never written are skipped by the scan via the
// fill count, so no clearing pass is needed.
// A result waits in the output register; the next sample is taken meanwhile
// and only its last step waits for the output register to empty.
module rolling_peak_axis_autoscale #(
   parameter int WINDOW = 200
) (
   input  logic                             clock,
   input  logic                             reset,
   rpaa_req_if.sink                         req_ch,
   rpaa_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [rpaa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rpaa_pkg::VAL_W-1:0]       csr_wdata
);
   import rpaa_pkg::*;

   localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;   // store address
   localparam int CW = $clog2(WINDOW + 1);                 // fill count, holds WINDOW
   localparam logic [AW-1:0] LAST_PTR = AW'(WINDOW - 1);
   localparam logic [CW-1:0] FULL     = CW'(WINDOW);

   // configuration
   logic [VAL_W-1:0]  threshold_ff;
   logic [HEAD_W-1:0] headroom_ff;
   logic [VAL_W-1:0]  baseline_ff;

   // sequencer and window bookkeeping
   state_type        state_ff, state_in;
   logic [AW-1:0]    wptr_ff, wptr_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic             rd_valid_ff;
   logic [VAL_W-1:0] best_ff, best_in;
   logic [VAL_W-1:0] last_limit_ff, last_limit_in;

   // output register
   logic             rsp_valid_ff;
   logic [VAL_W-1:0] rsp_whole_ff;
   logic [VAL_W-1:0] rsp_peak_ff;
   logic [VAL_W-1:0] rsp_limit_ff;
   logic             rsp_changed_ff;

   logic             req_take;
   logic             scan_last;
   logic             rsp_free;
   logic             finish;
   logic [VAL_W-1:0] whole;
   logic [VAL_W-1:0] rd_data;
   logic [VAL_W-1:0] limit;
   logic             mem_we;
   logic             mem_re;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign scan_last    = (CW'(scan_ff + 1'b1) == fill_ff);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign finish       = (state_ff == ST_FINISH) && rsp_free;
   assign mem_we       = (state_ff == ST_WRITE);
   assign mem_re       = (state_ff == ST_SCAN);

   rpaa_div10 u_div10 (
      .clock    (clock),
      .load     (req_take),
      .dividend (req_ch.speed_tenths),
      .quotient (whole)
   );

   rpaa_window_ram #(
      .DEPTH (WINDOW),
      .AW    (AW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wptr_ff),
      .wr_data (whole),
      .rd_en   (mem_re),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // axis limit from the finished peak; the sum stays below 6809 so 13 bits hold it
   always_comb begin
      if (best_ff > threshold_ff) begin
         limit = VAL_W'(best_ff + VAL_W'(headroom_ff));
      end else begin
         limit = baseline_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      wptr_in       = wptr_ff;
      fill_in       = fill_ff;
      scan_in       = scan_ff;
      best_in       = best_ff;
      last_limit_in = last_limit_ff;

      // running maximum over the read data as it lands
      if (rd_valid_ff && (rd_data > best_ff)) begin
         best_in = rd_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wptr_in  = (wptr_ff == LAST_PTR) ? '0 : AW'(wptr_ff + 1'b1);
            if (fill_ff != FULL) begin
               fill_in = CW'(fill_ff + 1'b1);
            end
            scan_in  = '0;
            best_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            scan_in = CW'(scan_ff + 1'b1);
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               last_limit_in = limit;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wptr_ff       <= '0;
         fill_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         last_limit_ff <= RST_LAST_LIMIT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wptr_ff       <= wptr_in;
         fill_ff       <= fill_in;
         rd_valid_ff   <= mem_re;
         last_limit_ff <= last_limit_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      best_ff <= best_in;
      if (finish) begin
         rsp_whole_ff   <= whole;
         rsp_peak_ff    <= best_ff;
         rsp_limit_ff   <= limit;
         rsp_changed_ff <= (limit != last_limit_ff);
      end
   end

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= RST_THRESHOLD;
         headroom_ff  <= RST_HEADROOM;
         baseline_ff  <= RST_BASELINE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_wdata;
            CSR_HEADROOM:  headroom_ff  <= csr_wdata[HEAD_W-1:0];
            CSR_BASELINE:  baseline_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.speed_whole   = rsp_whole_ff;
   assign rsp_ch.window_peak   = rsp_peak_ff;
   assign rsp_ch.axis_limit    = rsp_limit_ff;
   assign rsp_ch.limit_changed = rsp_changed_ff;

   // scan never reads beyond the written part of the store
   a_scan_in_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff < fill_ff))
      else $error("scan address beyond fill count");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= FULL) && (wptr_ff <= LAST_PTR))
      else $error("fill count or write pointer out of range");

   // the peak covers the sample just written
   a_peak_covers_sample: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_peak_ff >= rsp_whole_ff))
      else $error("window peak below current sample");

   // a finished result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !finish)
      else $error("result overwritten while stalled");

   // last read lands in the drain cycle
   a_drain_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> rd_valid_ff)
      else $error("drain without pending read");

endmodule
